// ----- design/ffsa_pkg.sv -----
// Shared types, constants and command codes for the first-fit segment allocator.
// No dependencies; every other design file but ffsa_if takes its names from here by scope.
package ffsa_pkg;

    localparam int          MAX_SEGMENTS_DEF = 16;
    localparam logic [15:0] ARENA_RESET      = 16'd1024;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    // request codes
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    // table write selects
    localparam logic [2:0] WR_NONE      = 3'd0;
    localparam logic [2:0] WR_SHIFT     = 3'd1;
    localparam logic [2:0] WR_COPY      = 3'd2;
    localparam logic [2:0] WR_TAIL      = 3'd3;
    localparam logic [2:0] WR_HEAD_USED = 3'd4;
    localparam logic [2:0] WR_HEAD_FREE = 3'd5;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] len;
        logic        free;
    } t_seg;

    typedef struct packed {
        logic       start;
        logic       rd;
        logic       rd_prev;
        logic       ptr_inc;
        logic       ptr_dec;
        logic       ptr_cnt;
        logic       seg_ld;
        logic       seg_acc;
        logic       tot_alloc;
        logic       tot_release;
        logic       cnt_inc;
        logic       cnt_dst;
        logic       dst_init;
        logic       dst_inc;
        logic [2:0] wr_sel;
        logic       res_ld;
        logic [1:0] res_code;
        logic       out_ld;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic size_zero;
        logic ptr_lt_cnt;
        logic fits;
        logic bigger;
        logic full;
        logic match;
        logic rd_free;
        logic shift_more;
    } t_sts;

endpackage

// ----- design/ffsa_if.sv -----
// Handshake channel interfaces for requests and results.
// Depends on nothing.
interface ffsa_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] request_size;
    logic [15:0] block_address;

    modport source (output valid, func, request_size, block_address, input ready);
    modport sink   (input valid, func, request_size, block_address, output ready);
endinterface

interface ffsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] granted_address;
    logic [15:0] free_total;
    logic [15:0] used_total;

    modport source (output valid, status, granted_address, free_total, used_total,
                    input ready);
    modport sink   (input valid, status, granted_address, free_total, used_total,
                    output ready);
endinterface

// ----- design/ffsa_datapath.sv -----
// Segment table memory, pointers, running totals and result registers.
// Depends on ffsa_pkg; driven by ffsa_ctrl through t_cmd.
module ffsa_datapath #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_func,
    input  logic [15:0]       i_size,
    input  logic [15:0]       i_addr,
    input  ffsa_pkg::t_cmd    i_cmd,
    output ffsa_pkg::t_sts    o_sts,
    output logic [1:0]        o_status,
    output logic [15:0]       o_granted,
    output logic [15:0]       o_free_total,
    output logic [15:0]       o_used_total
);
    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);
    localparam logic [CW-1:0] ONE     = CW'(1);

    ffsa_pkg::t_seg r_mem [MAX_SEGMENTS];
    ffsa_pkg::t_seg r_rdata;
    ffsa_pkg::t_seg r_seg;

    logic          r_func;
    logic [15:0]   r_size;
    logic [15:0]   r_addr;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_ptr;
    logic [CW-1:0] r_dst;
    logic [CW-1:0] r_base;
    logic [15:0]   r_free_tot;
    logic [15:0]   r_used_tot;
    logic [1:0]    r_pend_status;
    logic [15:0]   r_pend_grant;
    logic [1:0]    r_status;
    logic [15:0]   r_granted;
    logic [15:0]   r_out_free;
    logic [15:0]   r_out_used;

    logic           w_we;
    logic [CW-1:0]  w_waddr;
    ffsa_pkg::t_seg w_wdata;
    logic [CW-1:0]  w_raddr;
    logic [CW-1:0]  w_base1;

    assign w_base1 = r_base + ONE;
    assign w_raddr = i_cmd.rd_prev ? (r_ptr - ONE) : r_ptr;

    always_comb begin
        w_we    = 1'b1;
        w_waddr = '0;
        w_wdata = r_rdata;
        if (!i_rst_n) begin
            w_wdata = '{start: 16'd0, len: ffsa_pkg::ARENA_RESET, free: 1'b1};
        end else if (i_cfg_we) begin
            w_wdata = '{start: 16'd0, len: i_cfg_wdata, free: 1'b1};
        end else begin
            case (i_cmd.wr_sel)
                ffsa_pkg::WR_SHIFT: begin
                    w_waddr = r_ptr;
                end
                ffsa_pkg::WR_COPY: begin
                    w_waddr = r_dst;
                end
                ffsa_pkg::WR_TAIL: begin
                    w_waddr = w_base1;
                    w_wdata = '{start: r_seg.start + r_size, len: r_seg.len - r_size,
                                free: 1'b1};
                end
                ffsa_pkg::WR_HEAD_USED: begin
                    w_waddr = r_base;
                    w_wdata = '{start: r_seg.start, len: r_size, free: 1'b0};
                end
                ffsa_pkg::WR_HEAD_FREE: begin
                    w_waddr = r_base;
                    w_wdata = '{start: r_seg.start, len: r_seg.len, free: 1'b1};
                end
                default: begin
                    w_we = 1'b0;
                end
            endcase
        end
    end

    // table: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr[AW-1:0]] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[w_raddr[AW-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= ONE;
            r_free_tot <= ffsa_pkg::ARENA_RESET;
            r_used_tot <= 16'd0;
        end else if (i_cfg_we) begin
            r_cnt      <= ONE;
            r_free_tot <= i_cfg_wdata;
            r_used_tot <= 16'd0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + ONE;
            end else if (i_cmd.cnt_dst) begin
                r_cnt <= r_dst;
            end
            if (i_cmd.tot_alloc) begin
                r_free_tot <= r_free_tot - r_size;
                r_used_tot <= r_used_tot + r_size;
            end else if (i_cmd.tot_release && !r_rdata.free) begin
                r_free_tot <= r_free_tot + r_rdata.len;
                r_used_tot <= r_used_tot - r_rdata.len;
            end
        end
    end

    // pointers and payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func <= i_func;
            r_size <= i_size;
            r_addr <= i_addr;
            r_ptr  <= '0;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + ONE;
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= r_ptr - ONE;
        end else if (i_cmd.ptr_cnt) begin
            r_ptr <= r_cnt;
        end
        if (i_cmd.seg_ld) begin
            r_seg  <= r_rdata;
            r_base <= r_ptr;
        end else if (i_cmd.seg_acc) begin
            r_seg.len <= r_seg.len + r_rdata.len;
        end
        if (i_cmd.dst_init) begin
            r_dst <= w_base1;
        end else if (i_cmd.dst_inc) begin
            r_dst <= r_dst + ONE;
        end
        if (i_cmd.res_ld) begin
            r_pend_status <= i_cmd.res_code;
            r_pend_grant  <= (i_cmd.res_code == ffsa_pkg::ST_OK
                              && r_func == ffsa_pkg::FN_ALLOC) ? r_seg.start : 16'd0;
        end
        if (i_cmd.out_ld) begin
            r_status   <= r_pend_status;
            r_granted  <= r_pend_grant;
            r_out_free <= r_free_tot;
            r_out_used <= r_used_tot;
        end
    end

    assign o_sts.func       = r_func;
    assign o_sts.size_zero  = (r_size == 16'd0);
    assign o_sts.ptr_lt_cnt = (r_ptr < r_cnt);
    assign o_sts.fits       = r_rdata.free && (r_rdata.len >= r_size);
    assign o_sts.bigger     = (r_rdata.len > r_size);
    assign o_sts.full       = (r_cnt == CNT_MAX);
    assign o_sts.match      = (r_rdata.start == r_addr);
    assign o_sts.rd_free    = r_rdata.free;
    assign o_sts.shift_more = (r_ptr > w_base1);

    assign o_status     = r_status;
    assign o_granted    = r_granted;
    assign o_free_total = r_out_free;
    assign o_used_total = r_out_used;

endmodule

// ----- design/ffsa_ctrl.sv -----
// Sequencer: scan, split shift, merge and compaction passes over the table.
// Depends on ffsa_pkg; issues t_cmd to ffsa_datapath.
module ffsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    input  ffsa_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output ffsa_pkg::t_cmd o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK0  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_CK    = 4'd3;
    localparam logic [3:0] S_SHCK  = 4'd4;
    localparam logic [3:0] S_SHWR  = 4'd5;
    localparam logic [3:0] S_TAIL  = 4'd6;
    localparam logic [3:0] S_AHEAD = 4'd7;
    localparam logic [3:0] S_MRD   = 4'd8;
    localparam logic [3:0] S_MCK   = 4'd9;
    localparam logic [3:0] S_MHEAD = 4'd10;
    localparam logic [3:0] S_CRD   = 4'd11;
    localparam logic [3:0] S_CWR   = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_CHK0;
                end
            end
            S_CHK0: begin
                if (i_sts.func == ffsa_pkg::FN_ALLOC && i_sts.size_zero) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_code = ffsa_pkg::ST_BAD;
                    n_state        = S_FIN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (!i_sts.ptr_lt_cnt) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_code = (i_sts.func == ffsa_pkg::FN_ALLOC)
                                     ? ffsa_pkg::ST_NOFIT : ffsa_pkg::ST_BAD;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CK;
                end
            end
            S_CK: begin
                if (i_sts.func == ffsa_pkg::FN_ALLOC) begin
                    if (i_sts.fits && i_sts.bigger && i_sts.full) begin
                        o_cmd.res_ld   = 1'b1;
                        o_cmd.res_code = ffsa_pkg::ST_FULL;
                        n_state        = S_FIN;
                    end else if (i_sts.fits && i_sts.bigger) begin
                        o_cmd.seg_ld  = 1'b1;
                        o_cmd.ptr_cnt = 1'b1;
                        n_state       = S_SHCK;
                    end else if (i_sts.fits) begin
                        o_cmd.seg_ld = 1'b1;
                        n_state      = S_AHEAD;
                    end else begin
                        o_cmd.ptr_inc = 1'b1;
                        n_state       = S_RD;
                    end
                end else if (i_sts.match) begin
                    o_cmd.seg_ld      = 1'b1;
                    o_cmd.tot_release = 1'b1;
                    o_cmd.ptr_inc     = 1'b1;
                    n_state           = S_MRD;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_SHCK: begin
                if (i_sts.shift_more) begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_SHWR;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_SHWR: begin
                o_cmd.wr_sel  = ffsa_pkg::WR_SHIFT;
                o_cmd.ptr_dec = 1'b1;
                n_state       = S_SHCK;
            end
            S_TAIL: begin
                o_cmd.wr_sel  = ffsa_pkg::WR_TAIL;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_AHEAD;
            end
            S_AHEAD: begin
                o_cmd.wr_sel    = ffsa_pkg::WR_HEAD_USED;
                o_cmd.tot_alloc = 1'b1;
                o_cmd.res_ld    = 1'b1;
                o_cmd.res_code  = ffsa_pkg::ST_OK;
                n_state         = S_FIN;
            end
            S_MRD: begin
                if (i_sts.ptr_lt_cnt) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_MCK;
                end else begin
                    n_state = S_MHEAD;
                end
            end
            S_MCK: begin
                if (i_sts.rd_free) begin
                    o_cmd.seg_acc = 1'b1;
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = S_MRD;
                end else begin
                    n_state = S_MHEAD;
                end
            end
            S_MHEAD: begin
                o_cmd.wr_sel   = ffsa_pkg::WR_HEAD_FREE;
                o_cmd.dst_init = 1'b1;
                n_state        = S_CRD;
            end
            S_CRD: begin
                if (i_sts.ptr_lt_cnt) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CWR;
                end else begin
                    o_cmd.cnt_dst  = 1'b1;
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_code = ffsa_pkg::ST_OK;
                    n_state        = S_FIN;
                end
            end
            S_CWR: begin
                o_cmd.wr_sel  = ffsa_pkg::WR_COPY;
                o_cmd.ptr_inc = 1'b1;
                o_cmd.dst_inc = 1'b1;
                n_state       = S_CRD;
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- design/first_fit_segment_allocator.sv -----
// First-fit segment allocator top level; needs ffsa_pkg, ffsa_if, ffsa_ctrl, ffsa_datapath.
// A zero-size allocate is rejected straight after the size check; any other request
//   waits on each table entry that is scanned, shifted or copied.
// One request at a time; the next beat is taken the cycle after the result loads, and
//   the result loads only once the result register is free.
// Reset (sync, active low) leaves one free segment of 1024 bytes at 0.
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    ffsa_req_if.sink    i_req,
    ffsa_rsp_if.source  o_rsp
);
    // command/status bundle between sequencer and datapath
    ffsa_pkg::t_cmd w_cmd;
    ffsa_pkg::t_sts w_sts;
    logic           w_in_ready;

    assign i_req.ready = w_in_ready;

    // Sequencer. Request beats are taken only when idle; the result
    // register lets the next beat in while a result still waits.
    ffsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_in_ready  (w_in_ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    // Table, running totals (kept incrementally, mod 2^16) and result regs.
    // Configuration writes restart the table at entry 0.
    ffsa_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_func       (i_req.func),
        .i_size       (i_req.request_size),
        .i_addr       (i_req.block_address),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_status     (o_rsp.status),
        .o_granted    (o_rsp.granted_address),
        .o_free_total (o_rsp.free_total),
        .o_used_total (o_rsp.used_total)
    );

endmodule

// ----- design/ffsa_checker.sv -----
// Port-level checks for the allocator and the bind that attaches them.
// Depends on ffsa_pkg and first_fit_segment_allocator.
module ffsa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [15:0] i_cfg_wdata,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [15:0] i_granted,
    input logic [15:0] i_free_total,
    input logic [15:0] i_used_total
);
    logic [15:0] r_arena;
    logic [15:0] w_sum;

    assign w_sum = i_free_total + i_used_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena <= ffsa_pkg::ARENA_RESET;
        end else if (i_cfg_we) begin
            r_arena <= i_cfg_wdata;
        end
    end

    a_no_out_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable({i_status, i_granted, i_free_total,
                                                 i_used_total}))
        else $error("stalled result changed");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ffsa_pkg::ST_OK |-> i_granted == 16'd0)
        else $error("grant on failed request");

    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> w_sum == r_arena)
        else $error("free plus used differs from arena");

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_we     (i_cfg_we),
    .i_cfg_wdata  (i_cfg_wdata),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_granted    (o_rsp.granted_address),
    .i_free_total (o_rsp.free_total),
    .i_used_total (o_rsp.used_total)
);
